// File: hw/rtl/impm_pkg.sv
// impm_pkg: widths, codes and state type shared by the impact magnitude monitor
// no dependencies; compile first
package impm_pkg;

    localparam int ACCEL_W   = 16;
    localparam int ID_W      = 8;
    localparam int MAG_W     = 16;
    localparam int SQ_W      = 2 * ACCEL_W;
    localparam int SUM_W     = 24;
    localparam int COUNT_W   = 9;
    localparam int CFG_W     = 16;
    localparam int CLASS_W   = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] WARNING_RESET  = 16'd768;
    localparam logic [CFG_W-1:0] CRITICAL_RESET = 16'd1536;

    localparam logic [CFG_IDX_W-1:0] REG_WARNING  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CRITICAL = 1'b1;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_NORMAL   = 2'd0,
        CLASS_WARNING  = 2'd1,
        CLASS_CRITICAL = 2'd2
    } class_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_UPDATE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_EMIT
    } state_t;

endpackage

// File: hw/rtl/impm_if.sv
// impm_sample_if / impm_result_if: valid-ready channels for samples and results
// depends on impm_pkg
interface impm_sample_if;
    logic                                valid;
    logic                                ready;
    logic [impm_pkg::ID_W-1:0]           sensor_id;
    logic signed [impm_pkg::ACCEL_W-1:0] accel_x;
    logic signed [impm_pkg::ACCEL_W-1:0] accel_y;
    logic signed [impm_pkg::ACCEL_W-1:0] accel_z;
    logic                                batch_end;

    modport source (output valid, sensor_id, accel_x, accel_y, accel_z, batch_end,
                    input ready);
    modport sink (input valid, sensor_id, accel_x, accel_y, accel_z, batch_end,
                  output ready);
endinterface

interface impm_result_if;
    logic                             valid;
    logic                             ready;
    logic [impm_pkg::MAG_W-1:0]       magnitude;
    logic [impm_pkg::CLASS_W-1:0]     sample_class;
    logic                             summary_valid;
    logic [impm_pkg::MAG_W-1:0]       average_magnitude;
    logic [impm_pkg::MAG_W-1:0]       peak_magnitude;
    logic [impm_pkg::ID_W-1:0]        peak_sensor;
    logic [impm_pkg::COUNT_W-1:0]     abnormal_count;
    logic [impm_pkg::CLASS_W-1:0]     batch_status;

    modport source (output valid, magnitude, sample_class, summary_valid,
                    average_magnitude, peak_magnitude, peak_sensor, abnormal_count,
                    batch_status, input ready);
    modport sink (input valid, magnitude, sample_class, summary_valid,
                  average_magnitude, peak_magnitude, peak_sensor, abnormal_count,
                  batch_status, output ready);
endinterface

// File: hw/rtl/impact_magnitude_monitor.sv
// impact_magnitude_monitor: top level of the impact magnitude monitor
// depends on impm_pkg, impm_if, impm_sqrt, impm_div
//
// Takes one acceleration item at a time and returns one result item for each: the
// floor square root of x*x + y*y + z*z, its class against the warning and critical
// levels, and, on the item that closes a batch (batch_end set or MAX_SAMPLES items
// counted), the batch average, first peak with its sensor id, abnormal count and
// status. The result is registered after bit-serial squaring, the bit-serial square
// root with its start state, the batch update and the output load; the next item is
// taken only once that result has been loaded, so items do not overlap in the
// datapath. An item that closes a batch also passes the bit-serial average divider,
// with its start state, between the batch update and the output load.
// The result sits in an output register, so the next item is taken while it waits.
// Threshold writes are expected only while no item is in flight.
module impact_magnitude_monitor
#(
    parameter int unsigned MAX_SAMPLES = 256
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_en,
    input  logic [impm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [impm_pkg::CFG_W-1:0]        cfg_data,
    impm_sample_if.sink                       samples,
    impm_result_if.source                     results
);

    localparam int SQ_STEP_W = $clog2(impm_pkg::ACCEL_W);

    // thresholds
    logic [impm_pkg::CFG_W-1:0] warn_reg, warn_next;
    logic [impm_pkg::CFG_W-1:0] crit_reg, crit_next;

    // control
    impm_pkg::state_t           state_reg, state_next;
    logic [SQ_STEP_W-1:0]       step_reg, step_next;
    logic                       accept_in;
    logic                       square_en;
    logic                       sqrt_start;
    logic                       update_en;
    logic                       div_start;
    logic                       emit_load;

    // item and squaring datapath
    logic [impm_pkg::ID_W-1:0]    id_reg, id_next;
    logic                         last_reg, last_next;
    logic [impm_pkg::ACCEL_W-1:0] mx_reg, mx_next, my_reg, my_next, mz_reg, mz_next;
    logic [impm_pkg::ACCEL_W-1:0] bx_reg, bx_next, by_reg, by_next, bz_reg, bz_next;
    logic [impm_pkg::SQ_W-1:0]    sq_reg, sq_next;
    logic [impm_pkg::ACCEL_W-1:0] tx, ty, tz;

    // per-item result
    logic [impm_pkg::MAG_W-1:0]   mag_reg, mag_next;
    impm_pkg::class_t             class_reg, class_next;
    logic                         close_reg, close_next;

    // batch accumulators
    logic [impm_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [impm_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [impm_pkg::COUNT_W-1:0] abn_reg, abn_next;
    logic [impm_pkg::MAG_W-1:0]   peak_reg, peak_next;
    logic [impm_pkg::ID_W-1:0]    peak_id_reg, peak_id_next;

    logic [impm_pkg::SUM_W:0]     sum_wide;
    logic [impm_pkg::SUM_W-1:0]   sum_upd;
    logic [impm_pkg::COUNT_W-1:0] count_upd;
    logic [impm_pkg::COUNT_W-1:0] abn_upd;
    logic                         take_peak;
    logic                         close_now;
    impm_pkg::class_t             sample_cls;
    impm_pkg::class_t             status;

    // serial units
    logic                         sqrt_done;
    logic [impm_pkg::MAG_W-1:0]   sqrt_root;
    logic                         div_done;
    logic [impm_pkg::MAG_W-1:0]   div_quot;

    // output register
    logic                         out_valid_reg, out_valid_next;
    logic [impm_pkg::MAG_W-1:0]   out_mag_reg, out_mag_next;
    logic [impm_pkg::CLASS_W-1:0] out_class_reg, out_class_next;
    logic                         out_sum_valid_reg, out_sum_valid_next;
    logic [impm_pkg::MAG_W-1:0]   out_avg_reg, out_avg_next;
    logic [impm_pkg::MAG_W-1:0]   out_peak_reg, out_peak_next;
    logic [impm_pkg::ID_W-1:0]    out_peak_id_reg, out_peak_id_next;
    logic [impm_pkg::COUNT_W-1:0] out_abn_reg, out_abn_next;
    logic [impm_pkg::CLASS_W-1:0] out_status_reg, out_status_next;

    function automatic logic [impm_pkg::ACCEL_W-1:0] abs_val
    (
        input logic [impm_pkg::ACCEL_W-1:0] v
    );
        logic [impm_pkg::ACCEL_W-1:0] neg;
        neg = ~v + 1'b1;
        abs_val = v[impm_pkg::ACCEL_W-1] ? neg : v;
    endfunction

    function automatic impm_pkg::class_t classify
    (
        input logic [impm_pkg::MAG_W-1:0] mag,
        input logic [impm_pkg::CFG_W-1:0] warn,
        input logic [impm_pkg::CFG_W-1:0] crit
    );
        impm_pkg::class_t c;
        priority if (mag >= crit)
            c = impm_pkg::CLASS_CRITICAL;
        else if (mag >= warn)
            c = impm_pkg::CLASS_WARNING;
        else
            c = impm_pkg::CLASS_NORMAL;
        return c;
    endfunction

    // threshold registers
    always_comb
    begin
        warn_next = warn_reg;
        crit_next = crit_reg;
        if (cfg_en)
        begin
            unique case (cfg_index)
                impm_pkg::REG_WARNING:  warn_next = cfg_data;
                impm_pkg::REG_CRITICAL: crit_next = cfg_data;
                default:                warn_next = warn_reg;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            impm_pkg::ST_IDLE:
                if (samples.valid)
                    state_next = impm_pkg::ST_SQUARE;
            impm_pkg::ST_SQUARE:
                if (step_reg == SQ_STEP_W'(impm_pkg::ACCEL_W - 1))
                    state_next = impm_pkg::ST_ROOT_GO;
            impm_pkg::ST_ROOT_GO:
                state_next = impm_pkg::ST_ROOT_WAIT;
            impm_pkg::ST_ROOT_WAIT:
                if (sqrt_done)
                    state_next = impm_pkg::ST_UPDATE;
            impm_pkg::ST_UPDATE:
                state_next = close_now ? impm_pkg::ST_DIV_GO : impm_pkg::ST_EMIT;
            impm_pkg::ST_DIV_GO:
                state_next = impm_pkg::ST_DIV_WAIT;
            impm_pkg::ST_DIV_WAIT:
                if (div_done)
                    state_next = impm_pkg::ST_EMIT;
            impm_pkg::ST_EMIT:
                if (!out_valid_reg || results.ready)
                    state_next = impm_pkg::ST_IDLE;
            default:
                state_next = impm_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        accept_in  = 1'b0;
        square_en  = 1'b0;
        sqrt_start = 1'b0;
        update_en  = 1'b0;
        div_start  = 1'b0;
        emit_load  = 1'b0;
        unique case (state_reg)
            impm_pkg::ST_IDLE:      accept_in  = 1'b1;
            impm_pkg::ST_SQUARE:    square_en  = 1'b1;
            impm_pkg::ST_ROOT_GO:   sqrt_start = 1'b1;
            impm_pkg::ST_ROOT_WAIT: sqrt_start = 1'b0;
            impm_pkg::ST_UPDATE:    update_en  = 1'b1;
            impm_pkg::ST_DIV_GO:    div_start  = 1'b1;
            impm_pkg::ST_DIV_WAIT:  div_start  = 1'b0;
            impm_pkg::ST_EMIT:      emit_load  = !out_valid_reg || results.ready;
            default:                accept_in  = 1'b0;
        endcase
    end

    assign samples.ready = accept_in;

    // sum of squares, one multiplier bit per axis per cycle, msb first
    always_comb
    begin
        tx = bx_reg[impm_pkg::ACCEL_W-1] ? mx_reg : '0;
        ty = by_reg[impm_pkg::ACCEL_W-1] ? my_reg : '0;
        tz = bz_reg[impm_pkg::ACCEL_W-1] ? mz_reg : '0;

        id_next   = id_reg;
        last_next = last_reg;
        mx_next   = mx_reg;
        my_next   = my_reg;
        mz_next   = mz_reg;
        bx_next   = bx_reg;
        by_next   = by_reg;
        bz_next   = bz_reg;
        sq_next   = sq_reg;
        step_next = step_reg;
        if (accept_in && samples.valid)
        begin
            id_next   = samples.sensor_id;
            last_next = samples.batch_end;
            mx_next   = abs_val(samples.accel_x);
            my_next   = abs_val(samples.accel_y);
            mz_next   = abs_val(samples.accel_z);
            bx_next   = abs_val(samples.accel_x);
            by_next   = abs_val(samples.accel_y);
            bz_next   = abs_val(samples.accel_z);
            sq_next   = '0;
            step_next = '0;
        end
        else if (square_en)
        begin
            sq_next   = {sq_reg[impm_pkg::SQ_W-2:0], 1'b0} + impm_pkg::SQ_W'(tx)
                        + impm_pkg::SQ_W'(ty) + impm_pkg::SQ_W'(tz);
            bx_next   = {bx_reg[impm_pkg::ACCEL_W-2:0], 1'b0};
            by_next   = {by_reg[impm_pkg::ACCEL_W-2:0], 1'b0};
            bz_next   = {bz_reg[impm_pkg::ACCEL_W-2:0], 1'b0};
            step_next = step_reg + 1'b1;
        end
    end

    impm_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sq_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // batch update
    always_comb
    begin
        sample_cls = classify(sqrt_root, warn_reg, crit_reg);
        take_peak  = (count_reg == '0) || (sqrt_root > peak_reg);
        sum_wide   = {1'b0, sum_reg} + (impm_pkg::SUM_W + 1)'(sqrt_root);
        sum_upd    = sum_wide[impm_pkg::SUM_W] ? '1 : sum_wide[impm_pkg::SUM_W-1:0];
        count_upd  = (&count_reg) ? count_reg : count_reg + 1'b1;
        abn_upd    = (sqrt_root >= warn_reg && !(&abn_reg)) ? abn_reg + 1'b1 : abn_reg;
        close_now  = last_reg || (32'(count_upd) >= MAX_SAMPLES);

        mag_next     = mag_reg;
        class_next   = class_reg;
        close_next   = close_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        abn_next     = abn_reg;
        peak_next    = peak_reg;
        peak_id_next = peak_id_reg;
        if (update_en)
        begin
            mag_next   = sqrt_root;
            class_next = sample_cls;
            close_next = close_now;
            sum_next   = sum_upd;
            count_next = count_upd;
            abn_next   = abn_upd;
            if (take_peak)
            begin
                peak_next    = sqrt_root;
                peak_id_next = id_reg;
            end
        end
        else if (emit_load && close_reg)
        begin
            sum_next     = '0;
            count_next   = '0;
            abn_next     = '0;
            peak_next    = '0;
            peak_id_next = '0;
        end
    end

    impm_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // result register
    always_comb
    begin
        priority if (peak_reg >= crit_reg)
            status = impm_pkg::CLASS_CRITICAL;
        else if (abn_reg != '0)
            status = impm_pkg::CLASS_WARNING;
        else
            status = impm_pkg::CLASS_NORMAL;

        out_valid_next     = out_valid_reg;
        out_mag_next       = out_mag_reg;
        out_class_next     = out_class_reg;
        out_sum_valid_next = out_sum_valid_reg;
        out_avg_next       = out_avg_reg;
        out_peak_next      = out_peak_reg;
        out_peak_id_next   = out_peak_id_reg;
        out_abn_next       = out_abn_reg;
        out_status_next    = out_status_reg;
        if (emit_load)
        begin
            out_valid_next     = 1'b1;
            out_mag_next       = mag_reg;
            out_class_next     = class_reg;
            out_sum_valid_next = close_reg;
            out_avg_next       = close_reg ? div_quot : '0;
            out_peak_next      = close_reg ? peak_reg : '0;
            out_peak_id_next   = close_reg ? peak_id_reg : '0;
            out_abn_next       = close_reg ? abn_reg : '0;
            out_status_next    = close_reg ? status : impm_pkg::CLASS_NORMAL;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign results.valid             = out_valid_reg;
    assign results.magnitude         = out_mag_reg;
    assign results.sample_class      = out_class_reg;
    assign results.summary_valid     = out_sum_valid_reg;
    assign results.average_magnitude = out_avg_reg;
    assign results.peak_magnitude    = out_peak_reg;
    assign results.peak_sensor       = out_peak_id_reg;
    assign results.abnormal_count    = out_abn_reg;
    assign results.batch_status      = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warn_reg      <= impm_pkg::WARNING_RESET;
            crit_reg      <= impm_pkg::CRITICAL_RESET;
            state_reg     <= impm_pkg::ST_IDLE;
            step_reg      <= '0;
            close_reg     <= 1'b0;
            sum_reg       <= '0;
            count_reg     <= '0;
            abn_reg       <= '0;
            peak_reg      <= '0;
            peak_id_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            warn_reg      <= warn_next;
            crit_reg      <= crit_next;
            state_reg     <= state_next;
            step_reg      <= step_next;
            close_reg     <= close_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            abn_reg       <= abn_next;
            peak_reg      <= peak_next;
            peak_id_reg   <= peak_id_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg            <= id_next;
        last_reg          <= last_next;
        mx_reg            <= mx_next;
        my_reg            <= my_next;
        mz_reg            <= mz_next;
        bx_reg            <= bx_next;
        by_reg            <= by_next;
        bz_reg            <= bz_next;
        sq_reg            <= sq_next;
        mag_reg           <= mag_next;
        class_reg         <= class_next;
        out_mag_reg       <= out_mag_next;
        out_class_reg     <= out_class_next;
        out_sum_valid_reg <= out_sum_valid_next;
        out_avg_reg       <= out_avg_next;
        out_peak_reg      <= out_peak_next;
        out_peak_id_reg   <= out_peak_id_next;
        out_abn_reg       <= out_abn_next;
        out_status_reg    <= out_status_next;
    end

    a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.summary_valid |->
            results.average_magnitude == '0 && results.peak_magnitude == '0 &&
            results.peak_sensor == '0 && results.abnormal_count == '0 &&
            results.batch_status == impm_pkg::CLASS_NORMAL)
        else $error("summary fields set on an item that does not close a batch");

    a_class_critical: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.sample_class == impm_pkg::CLASS_CRITICAL |->
            results.magnitude >= crit_reg)
        else $error("critical class below the critical level");

    a_status_critical: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.summary_valid &&
        results.batch_status == impm_pkg::CLASS_CRITICAL |->
            results.peak_magnitude >= crit_reg)
        else $error("critical batch status with peak below the critical level");

    a_sqrt_done: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> state_reg == impm_pkg::ST_ROOT_WAIT)
        else $error("square root finished outside its wait state");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == impm_pkg::ST_DIV_WAIT)
        else $error("divider finished outside its wait state");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready |=>
            state_reg == impm_pkg::ST_SQUARE && step_reg == '0)
        else $error("accepted item did not start squaring");

endmodule

// File: hw/rtl/impm_sqrt.sv
// impm_sqrt: bit-serial floor square root, one root bit per cycle
// depends on impm_pkg
module impm_sqrt
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [impm_pkg::SQ_W-1:0]   radicand,
    output logic                        done,
    output logic [impm_pkg::MAG_W-1:0]  root
);

    localparam int STEP_W = $clog2(impm_pkg::MAG_W);
    localparam int REM_W  = impm_pkg::MAG_W + 1;

    logic [impm_pkg::SQ_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]           rem_reg, rem_next;
    logic [impm_pkg::MAG_W-1:0] root_reg, root_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;

    logic [REM_W+1:0] trial_rem;
    logic [REM_W+1:0] trial_sub;
    logic [REM_W+1:0] diff;
    logic             fits;

    always_comb
    begin
        trial_rem = {rem_reg, rad_reg[impm_pkg::SQ_W-1 -: 2]};
        trial_sub = {1'b0, root_reg, 2'b01};
        fits      = trial_rem >= trial_sub;
        diff      = trial_rem - trial_sub;
    end

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[impm_pkg::SQ_W-3:0], 2'b00};
            rem_next  = fits ? diff[REM_W-1:0] : trial_rem[REM_W-1:0];
            root_next = {root_reg[impm_pkg::MAG_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(impm_pkg::MAG_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: hw/rtl/impm_div.sv
// impm_div: bit-serial restoring divider for the batch average, one quotient bit per cycle
// depends on impm_pkg; the quotient must fit in MAG_W bits
module impm_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [impm_pkg::SUM_W-1:0]    dividend,
    input  logic [impm_pkg::COUNT_W-1:0]  divisor,
    output logic                          done,
    output logic [impm_pkg::MAG_W-1:0]    quotient
);

    localparam int STEP_W = $clog2(impm_pkg::MAG_W);

    logic [impm_pkg::COUNT_W-1:0] rem_reg, rem_next;
    logic [impm_pkg::MAG_W-1:0]   q_reg, q_next;
    logic [impm_pkg::COUNT_W-1:0] dsr_reg, dsr_next;
    logic [STEP_W-1:0]            step_reg, step_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;

    logic [impm_pkg::COUNT_W:0] trial;
    logic [impm_pkg::COUNT_W:0] diff;
    logic                       fits;

    always_comb
    begin
        trial = {rem_reg, q_reg[impm_pkg::MAG_W-1]};
        fits  = trial >= {1'b0, dsr_reg};
        diff  = trial - {1'b0, dsr_reg};
    end

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        dsr_next  = dsr_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = impm_pkg::COUNT_W'(dividend[impm_pkg::SUM_W-1:impm_pkg::MAG_W]);
            q_next    = dividend[impm_pkg::MAG_W-1:0];
            dsr_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[impm_pkg::COUNT_W-1:0] : trial[impm_pkg::COUNT_W-1:0];
            q_next    = {q_reg[impm_pkg::MAG_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(impm_pkg::MAG_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
